>>> design/sas_pkg.sv
// shared types, constants and register codes for the alignment score block
`default_nettype none

package sas_pkg;

	localparam int SA_MAX_LEN = 256;
	localparam int SYM_W      = 8;
	localparam int COST_W     = 8;
	localparam int SCORE_W    = 19;
	localparam int CALC_W     = SCORE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int SCORE_MAX = (1 << (SCORE_W - 1)) - 1;
	localparam int SCORE_MIN = -(1 << (SCORE_W - 1));

	typedef logic [SYM_W-1:0]          sym_t;
	typedef logic [COST_W-1:0]         cost_t;
	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic signed [CALC_W-1:0]  calc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAP_COST      = 2'd0,
		REG_MISMATCH_COST = 2'd1,
		REG_MATCH_BONUS   = 2'd2
	} sas_reg_t;

	localparam cost_t GAP_COST_RST      = 8'd1;
	localparam cost_t MISMATCH_COST_RST = 8'd1;
	localparam cost_t MATCH_BONUS_RST   = 8'd10;

	typedef struct packed {
		cost_t gap;
		cost_t mismatch;
		cost_t match;
	} sas_cfg_t;

	// one column wave travelling along the cell row
	typedef struct packed {
		logic   valid;
		logic   first;
		logic   skip;
		logic   last;
		logic   ovf;
		sym_t   sym;
		score_t val;
		score_t diag;
	} sas_token_t;

endpackage

`default_nettype wire

>>> design/sas_item_if.sv
// input item channel: mode, symbol and last with valid/ready
`default_nettype none

interface sas_item_if import sas_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	sym_t symbol;
	logic last;

	modport source (output valid, output mode, output symbol, output last, input ready);
	modport sink (input valid, input mode, input symbol, input last, output ready);
endinterface

`default_nettype wire

>>> design/sas_result_if.sv
// result channel: score and overflow with valid/ready
`default_nettype none

interface sas_result_if import sas_pkg::*; ();
	logic   valid;
	logic   ready;
	score_t score;
	logic   overflow;

	modport source (output valid, output score, output overflow, input ready);
	modport sink (input valid, input score, input overflow, output ready);
endinterface

`default_nettype wire

>>> design/sas_cfg_if.sv
// configuration write channel: register index and data with valid/ready
`default_nettype none

interface sas_cfg_if import sas_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/sas_cell.sv
// one cell of the score row: holds a first-sequence symbol and its running score
`default_nettype none

module sas_cell import sas_pkg::*; #(
	parameter int MAX_LEN  = SA_MAX_LEN,
	parameter int CELL_IDX = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire sas_cfg_t                     cfg,
	input  wire logic [$clog2(MAX_LEN+1)-1:0] flen,
	input  wire logic                         load_en,
	input  wire logic [$clog2(MAX_LEN+1)-1:0] load_idx,
	input  wire sym_t                         load_sym,
	input  wire sas_token_t                   tok_in,
	output sas_token_t                        tok_out
);

	localparam int LW = $clog2(MAX_LEN + 1);

	sym_t       sym_q;
	score_t     score_q;
	sas_token_t tok_q;
	sas_token_t tok_d;
	score_t     new_val;
	logic       active;
	logic       update;
	calc_t      up_c;
	calc_t      left_c;
	calc_t      diag_c;
	calc_t      best;

	function automatic score_t clamp_score(input calc_t v);
		score_t r;
		if (v > calc_t'(SCORE_MAX)) begin
			r = score_t'(SCORE_MAX);
		end else if (v < calc_t'(SCORE_MIN)) begin
			r = score_t'(SCORE_MIN);
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

	assign active = LW'(CELL_IDX) < flen;
	assign update = tok_in.valid && active && !tok_in.skip;

	always_comb begin
		up_c   = calc_t'(tok_in.val) - calc_t'(cfg.gap);
		left_c = calc_t'(score_q) - calc_t'(cfg.gap);
		if (sym_q == tok_in.sym) begin
			diag_c = calc_t'(tok_in.diag) + calc_t'(cfg.match);
		end else begin
			diag_c = calc_t'(tok_in.diag) - calc_t'(cfg.mismatch);
		end
		best = up_c;
		if (left_c > best) begin
			best = left_c;
		end
		if (diag_c > best) begin
			best = diag_c;
		end
		if (tok_in.first || CELL_IDX == 0) begin
			new_val = '0;
		end else begin
			new_val = clamp_score(best);
		end
		tok_d = tok_in;
		if (update) begin
			tok_d.val  = new_val;
			tok_d.diag = score_q;
		end else if (tok_in.valid && active) begin
			tok_d.val = score_q;
		end
	end

	// symbol and score store
	always_ff @(posedge clk) begin
		if (load_en && load_idx == LW'(CELL_IDX)) begin
			sym_q <= load_sym;
		end
		if (advance && update) begin
			score_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

>>> design/sequence_alignment_score_top.sv
// top level: sequence control, configuration registers and the row of score cells
//
// items: mode 0 transfers load the first sequence one symbol per transfer, mode 1
// transfers stream the second sequence; last marks the final symbol of either.
// results: one transfer per mode 1 item with last set, carrying the final grid
// score in signed tenths and an overflow flag for a truncated sequence.
// cfg: writes gap_cost (index 0), mismatch_cost (1) and match_bonus (2); other
// indexes are dropped. Always ready.
// Each mode 1 item launches a column wave into a row of MAX_LEN cells; the wave
// moves one cell per cycle while the row is not held, and a wave with last set
// is captured in the output register as it leaves the last cell. Mode 1 items
// are taken one per cycle while the row is not held. A mode 0 item waits until
// no wave is left in the row.
// When a result waits on a stalled receiver the whole row holds and no mode 1
// item is taken. Reset empties the row and the output register, clears the
// sequence lengths and loads the register defaults; symbols and scores are not
// cleared.
`default_nettype none

module sequence_alignment_score_top import sas_pkg::*; #(
	parameter int MAX_LEN = SA_MAX_LEN
) (
	input wire logic clk,
	input wire logic arst_n,
	sas_item_if.sink     items,
	sas_result_if.source results,
	sas_cfg_if.sink      cfg
);

	localparam int LW = $clog2(MAX_LEN + 1);

	sas_cfg_t     cfg_q;
	logic [LW-1:0] first_length_q;
	logic [LW-1:0] second_index_q;
	logic [LW-1:0] inflight_q;
	logic          first_closed_q;
	logic          length_exceeded_q;
	logic          second_overflow_q;
	logic          out_valid_q;
	score_t        out_score_q;
	logic          out_ovf_q;

	logic          advance;
	logic          item_acc;
	logic          load_acc;
	logic          col_acc;
	logic [LW-1:0] base_len;
	logic          base_exc;
	logic          load_en;
	logic          skip;
	logic          tail_leave;
	sas_token_t    tok [MAX_LEN+1];

	assign advance   = !out_valid_q || results.ready;
	assign items.ready = items.mode ? advance : (inflight_q == '0);
	assign item_acc  = items.valid && items.ready;
	assign load_acc  = item_acc && !items.mode;
	assign col_acc   = item_acc && items.mode;
	assign cfg.ready = 1'b1;

	assign base_len = first_closed_q ? '0 : first_length_q;
	assign base_exc = first_closed_q ? 1'b0 : length_exceeded_q;
	assign load_en  = load_acc && (base_len < LW'(MAX_LEN));
	assign skip     = second_index_q == LW'(MAX_LEN);

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = col_acc;
		tok[0].first = second_index_q == '0;
		tok[0].skip  = skip;
		tok[0].last  = items.last;
		tok[0].ovf   = length_exceeded_q || second_overflow_q || skip;
		tok[0].sym   = items.symbol;
	end

	assign tail_leave = advance && tok[MAX_LEN].valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap      <= GAP_COST_RST;
			cfg_q.mismatch <= MISMATCH_COST_RST;
			cfg_q.match    <= MATCH_BONUS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (sas_reg_t'(cfg.index))
				REG_GAP_COST:      cfg_q.gap      <= cfg.data;
				REG_MISMATCH_COST: cfg_q.mismatch <= cfg.data;
				REG_MATCH_BONUS:   cfg_q.match    <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequence bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_length_q    <= '0;
			second_index_q    <= '0;
			first_closed_q    <= 1'b0;
			length_exceeded_q <= 1'b0;
			second_overflow_q <= 1'b0;
		end else if (load_acc) begin
			first_closed_q    <= items.last;
			second_index_q    <= '0;
			second_overflow_q <= 1'b0;
			if (load_en) begin
				first_length_q    <= base_len + LW'(1);
				length_exceeded_q <= base_exc;
			end else begin
				first_length_q    <= base_len;
				length_exceeded_q <= 1'b1;
			end
		end else if (col_acc) begin
			first_closed_q <= 1'b1;
			if (items.last) begin
				second_index_q    <= '0;
				second_overflow_q <= 1'b0;
			end else if (skip) begin
				second_overflow_q <= 1'b1;
			end else begin
				second_index_q <= second_index_q + LW'(1);
			end
		end
	end

	// waves in the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (col_acc && !tail_leave) begin
			inflight_q <= inflight_q + LW'(1);
		end else if (tail_leave && !col_acc) begin
			inflight_q <= inflight_q - LW'(1);
		end
	end

	generate
		for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
			sas_cell #(
				.MAX_LEN  (MAX_LEN),
				.CELL_IDX (i)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (advance),
				.cfg      (cfg_q),
				.flen     (first_length_q),
				.load_en  (load_en),
				.load_idx (base_len),
				.load_sym (items.symbol),
				.tok_in   (tok[i]),
				.tok_out  (tok[i+1])
			);
		end
	endgenerate

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tok[MAX_LEN].valid && tok[MAX_LEN].last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tok[MAX_LEN].valid && tok[MAX_LEN].last) begin
			out_score_q <= tok[MAX_LEN].val;
			out_ovf_q   <= tok[MAX_LEN].ovf;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.score    = out_score_q;
	assign results.overflow = out_ovf_q;

`ifndef SYNTHESIS
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |-> inflight_q == '0)
		else $error("first-sequence symbol taken with waves in the row");

	a_tail_counted: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_LEN].valid |-> inflight_q != '0)
		else $error("wave leaving the row without being counted");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_length_q <= LW'(MAX_LEN) && second_index_q <= LW'(MAX_LEN))
		else $error("sequence position beyond the row");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok[MAX_LEN].valid && tok[MAX_LEN].last))
		else $error("result raised without a closing wave");
`endif

endmodule

`default_nettype wire
